// File: hw/rtl/i2af_pkg.sv
package i2af_pkg;

   // Fixed field widths of the request and response items.
   localparam int FIELD_W = 6;
   localparam int BASE_W = 5;
   localparam int CHAR_W = 8;
   localparam int REM_W = 5;

   // Character counter width; it covers a sign, the widest field and the deepest buffer.
   localparam int CNT_W = 7;

   // Number of characters one request may produce at most.
   localparam logic [CNT_W-1:0] OUT_LIMIT = 7'd63;

   // Quotient bits the divider resolves in one cycle.
   localparam int DIV_BITS = 8;

   // The only base in which the signed flag is honored.
   localparam logic [BASE_W-1:0] DECIMAL_BASE = 5'd10;
   localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

   // ASCII codes used by the formatter.
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_TEN = 8'd10;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIGIT,
      ST_SIGN,
      ST_PREP,
      ST_EMIT_SIGN,
      ST_EMIT_LPAD,
      ST_EMIT_TEXT,
      ST_EMIT_RPAD
   } state_type;

   // Source of the character loaded into the response register.
   typedef enum logic [1:0] {
      OUT_SIGN,
      OUT_PAD,
      OUT_TEXT
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_item;
      logic        div_step;
      logic        digit_write;
      logic        sign_write;
      logic        prep;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_done;
      logic quot_zero;
      logic buf_last;
      logic sign_first;
      logic right;
      logic prep_pad_any;
      logic pad_any;
      logic pad_one;
      logic ptr_zero;
      logic last_char;
      logic slot_free;
   } status_type;

   // Converts one digit value to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] digit,
                                                     input logic upper);
      logic [CHAR_W-1:0] letter_base;
      letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (CHAR_W'(digit) >= CHAR_TEN) begin
         digit_char = letter_base + CHAR_W'(digit) - CHAR_TEN;
      end else begin
         digit_char = CHAR_ZERO + CHAR_W'(digit);
      end
   endfunction

endpackage

// File: hw/rtl/i2af_ctrl.sv
module i2af_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  i2af_pkg::status_type   sts,
   output i2af_pkg::cmd_type      cmd
);

   i2af_pkg::state_type state_ff;
   i2af_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i2af_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      req_stall = 1'b1;
      cmd.load_item = 1'b0;
      cmd.div_step = 1'b0;
      cmd.digit_write = 1'b0;
      cmd.sign_write = 1'b0;
      cmd.prep = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_sel = i2af_pkg::OUT_PAD;
      case (state_ff)
         i2af_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = i2af_pkg::ST_DIV;
            end
         end
         i2af_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.step_done) begin
               state_in = i2af_pkg::ST_DIGIT;
            end
         end
         i2af_pkg::ST_DIGIT: begin
            cmd.digit_write = 1'b1;
            if (sts.quot_zero || sts.buf_last) begin
               state_in = i2af_pkg::ST_SIGN;
            end else begin
               state_in = i2af_pkg::ST_DIV;
            end
         end
         i2af_pkg::ST_SIGN: begin
            cmd.sign_write = 1'b1;
            state_in = i2af_pkg::ST_PREP;
         end
         i2af_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            if (sts.sign_first) begin
               state_in = i2af_pkg::ST_EMIT_SIGN;
            end else if (!sts.right && sts.prep_pad_any) begin
               state_in = i2af_pkg::ST_EMIT_LPAD;
            end else begin
               state_in = i2af_pkg::ST_EMIT_TEXT;
            end
         end
         i2af_pkg::ST_EMIT_SIGN: begin
            cmd.out_sel = i2af_pkg::OUT_SIGN;
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.last_char) begin
                  state_in = i2af_pkg::ST_IDLE;
               end else if (!sts.right && sts.pad_any) begin
                  state_in = i2af_pkg::ST_EMIT_LPAD;
               end else begin
                  state_in = i2af_pkg::ST_EMIT_TEXT;
               end
            end
         end
         i2af_pkg::ST_EMIT_LPAD: begin
            cmd.out_sel = i2af_pkg::OUT_PAD;
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.last_char) begin
                  state_in = i2af_pkg::ST_IDLE;
               end else if (sts.pad_one) begin
                  state_in = i2af_pkg::ST_EMIT_TEXT;
               end
            end
         end
         i2af_pkg::ST_EMIT_TEXT: begin
            cmd.out_sel = i2af_pkg::OUT_TEXT;
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.last_char) begin
                  state_in = i2af_pkg::ST_IDLE;
               end else if (sts.ptr_zero) begin
                  state_in = i2af_pkg::ST_EMIT_RPAD;
               end
            end
         end
         i2af_pkg::ST_EMIT_RPAD: begin
            cmd.out_sel = i2af_pkg::OUT_PAD;
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.last_char) begin
                  state_in = i2af_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = i2af_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted request always starts with a division.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == i2af_pkg::ST_IDLE) && req_valid |=> (state_ff == i2af_pkg::ST_DIV))
      else $error("Accepted request did not start the divider.");

   // The final character of a request returns the controller to idle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && sts.last_char |=> (state_ff == i2af_pkg::ST_IDLE))
      else $error("Controller kept running after the final character.");

   // At most one datapath command is active in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_item, cmd.div_step, cmd.digit_write, cmd.sign_write,
                cmd.prep, cmd.out_load}))
      else $error("Conflicting datapath commands.");

endmodule

// File: hw/rtl/i2af_datapath.sv
module i2af_datapath #(
   parameter int DIGIT_BUFFER_DEPTH = 33,
   parameter int VALUE_BITS = 32,
   parameter int MAX_FIELD_WIDTH = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [VALUE_BITS-1:0]                req_value,
   input  logic [i2af_pkg::BASE_W-1:0]          req_base,
   input  logic                                 req_signed_mode,
   input  logic [i2af_pkg::FIELD_W-1:0]         req_field_width,
   input  logic                                 req_left_justify,
   input  logic                                 req_zero_fill,
   input  logic                                 req_uppercase,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [i2af_pkg::CHAR_W-1:0]          rsp_character,
   output logic                                 rsp_last,
   input  i2af_pkg::cmd_type                    cmd,
   output i2af_pkg::status_type                 sts
);

   localparam int QBITS = ((VALUE_BITS + i2af_pkg::DIV_BITS - 1) / i2af_pkg::DIV_BITS)
                          * i2af_pkg::DIV_BITS;
   localparam int STEPS = QBITS / i2af_pkg::DIV_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int ADDR_W = $clog2(DIGIT_BUFFER_DEPTH);
   localparam int LEN_W = $clog2(DIGIT_BUFFER_DEPTH + 1);
   localparam int CNT_W = i2af_pkg::CNT_W;
   localparam int FIELD_W = i2af_pkg::FIELD_W;
   localparam int REM_W = i2af_pkg::REM_W;
   localparam int CHAR_W = i2af_pkg::CHAR_W;

   // Request attributes held for the whole conversion.
   logic [i2af_pkg::BASE_W-1:0] base_ff;
   logic                        neg_ff;
   logic                        sign_first_ff;
   logic                        right_ff;
   logic                        zero_ff;
   logic                        upper_ff;
   logic [FIELD_W-1:0]          width_ff;

   // Divider state.
   logic [QBITS-1:0]  q_ff;
   logic [REM_W-1:0]  r_ff;
   logic [STEP_W-1:0] step_ff;
   logic [QBITS-1:0]  q_step;
   logic [REM_W-1:0]  r_step;
   logic [REM_W:0]    trial;
   logic              fits;

   // Text buffer and emission state.
   logic [CHAR_W-1:0] buf_mem [DIGIT_BUFFER_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] ptr_ff;
   logic [ADDR_W-1:0] ptr_in;
   logic [FIELD_W-1:0] pad_ff;
   logic [CNT_W-1:0]  total_ff;
   logic [CNT_W-1:0]  emit_cnt_ff;
   logic              wr_en;
   logic [CHAR_W-1:0] wr_data;
   logic              sign_store;

   // Response register.
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic [CHAR_W-1:0] out_char;
   logic [CHAR_W-1:0] pad_char;

   // Request decode.
   logic [i2af_pkg::BASE_W-1:0] base_eff;
   logic [FIELD_W-1:0]          width_sat;
   logic                        neg_req;
   logic                        sign_first_req;
   logic [VALUE_BITS-1:0]       magnitude;

   // Field layout computed once the text is complete.
   logic [CNT_W-1:0]   width_wide;
   logic [CNT_W-1:0]   len_wide;
   logic [FIELD_W-1:0] pad_calc;
   logic [CNT_W-1:0]   total_calc;

   assign base_eff = (req_base < i2af_pkg::MIN_BASE) ? i2af_pkg::MIN_BASE : req_base;
   assign width_sat = (req_field_width > FIELD_W'(MAX_FIELD_WIDTH)) ?
                      FIELD_W'(MAX_FIELD_WIDTH) : req_field_width;
   assign neg_req = req_signed_mode && (req_base == i2af_pkg::DECIMAL_BASE) &&
                    req_value[VALUE_BITS-1];
   assign sign_first_req = neg_req && (width_sat != '0) && req_zero_fill;
   assign magnitude = neg_req ? (VALUE_BITS'(0) - req_value) : req_value;

   // Eight restoring division steps per cycle, quotient bits shifted in at the bottom.
   always_comb begin
      q_step = q_ff;
      r_step = r_ff;
      trial = '0;
      fits = 1'b0;
      for (int k = 0; k < i2af_pkg::DIV_BITS; k++) begin
         trial = {r_step, q_step[QBITS-1]};
         fits = trial >= {1'b0, base_ff};
         q_step = {q_step[QBITS-2:0], fits};
         r_step = fits ? REM_W'(trial - {1'b0, base_ff}) : trial[REM_W-1:0];
      end
   end

   // Pad count and character total for the finished text.
   assign width_wide = CNT_W'(width_ff);
   assign len_wide = CNT_W'(len_ff);
   assign pad_calc = (width_wide > len_wide) ? FIELD_W'(width_wide - len_wide) : '0;
   assign total_calc = CNT_W'(pad_calc) + len_wide + CNT_W'(sign_first_ff);

   // Buffer writes: digits, then the minus sign when it belongs to the text.
   assign sign_store = neg_ff && !sign_first_ff && (len_wide < CNT_W'(DIGIT_BUFFER_DEPTH));
   assign wr_en = cmd.digit_write || (cmd.sign_write && sign_store);
   assign wr_data = cmd.digit_write ? i2af_pkg::digit_char(r_ff, upper_ff) :
                    i2af_pkg::CHAR_MINUS;

   // Read pointer: the read data always matches the registered pointer.
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.prep) begin
         ptr_in = ADDR_W'(len_ff - LEN_W'(1));
      end else if (cmd.out_load && (cmd.out_sel == i2af_pkg::OUT_TEXT)) begin
         ptr_in = ptr_ff - ADDR_W'(1);
      end
   end

   // Text buffer memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[len_ff[ADDR_W-1:0]] <= wr_data;
      end
      rdata_ff <= buf_mem[ptr_in];
   end

   // Request capture, divider and layout registers.
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_item) begin
         base_ff <= base_eff;
         neg_ff <= neg_req;
         sign_first_ff <= sign_first_req;
         right_ff <= req_left_justify;
         zero_ff <= req_zero_fill;
         upper_ff <= req_uppercase;
         width_ff <= sign_first_req ? (width_sat - FIELD_W'(1)) : width_sat;
         q_ff <= QBITS'(magnitude);
         r_ff <= '0;
         step_ff <= '0;
         len_ff <= '0;
      end
      if (cmd.div_step) begin
         q_ff <= q_step;
         r_ff <= r_step;
         step_ff <= sts.step_done ? '0 : (step_ff + STEP_W'(1));
      end
      if (cmd.digit_write) begin
         r_ff <= '0;
      end
      if (wr_en) begin
         len_ff <= len_ff + LEN_W'(1);
      end
      if (cmd.prep) begin
         pad_ff <= pad_calc;
         total_ff <= total_calc;
         emit_cnt_ff <= '0;
      end
      if (cmd.out_load) begin
         emit_cnt_ff <= emit_cnt_ff + CNT_W'(1);
         if (cmd.out_sel == i2af_pkg::OUT_PAD) begin
            pad_ff <= pad_ff - FIELD_W'(1);
         end
      end
   end

   // Character selection for the response register.
   assign pad_char = zero_ff ? i2af_pkg::CHAR_ZERO : i2af_pkg::CHAR_SPACE;
   always_comb begin
      case (cmd.out_sel)
         i2af_pkg::OUT_SIGN: out_char = i2af_pkg::CHAR_MINUS;
         i2af_pkg::OUT_PAD: out_char = pad_char;
         i2af_pkg::OUT_TEXT: out_char = rdata_ff;
         default: out_char = pad_char;
      endcase
   end

   // Response register; it is free when empty or when its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         char_ff <= out_char;
         last_ff <= sts.last_char;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

   // Status to the controller.
   assign sts.step_done = (step_ff == STEP_W'(STEPS - 1));
   assign sts.quot_zero = (q_ff == '0);
   assign sts.buf_last = (len_wide == CNT_W'(DIGIT_BUFFER_DEPTH - 1));
   assign sts.sign_first = sign_first_ff;
   assign sts.right = right_ff;
   assign sts.prep_pad_any = (pad_calc != '0);
   assign sts.pad_any = (pad_ff != '0);
   assign sts.pad_one = (pad_ff == FIELD_W'(1));
   assign sts.ptr_zero = (ptr_ff == '0);
   assign sts.last_char = (emit_cnt_ff == (total_ff - CNT_W'(1))) ||
                          (emit_cnt_ff == (i2af_pkg::OUT_LIMIT - CNT_W'(1)));
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;

   // A character is never loaded over one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Response register overwritten while stalled.");

   // Text reads stay inside the filled part of the buffer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (cmd.out_sel == i2af_pkg::OUT_TEXT) |-> (LEN_W'(ptr_ff) < len_ff))
      else $error("Text read beyond the stored characters.");

   // Digit writes never run past the end of the buffer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.digit_write |-> (len_wide < CNT_W'(DIGIT_BUFFER_DEPTH)))
      else $error("Digit buffer overflow.");

endmodule

// File: hw/rtl/integer_to_ascii_formatter_core.sv
// An accepted word is divided one digit at a time by the 8-bit-per-cycle divider; each digit
// is written to the digit buffer, then the sign is handled and the field layout is set before
// the first character. Characters then leave at one per cycle while rsp_stall is low; the next
// request is taken the cycle after the final character is loaded.
// Reset is synchronous and active high; it clears the controller and the response valid.
// The digit buffer is not cleared: every entry is written before it is read.
module integer_to_ascii_formatter_core #(
   parameter int DIGIT_BUFFER_DEPTH = 33,
   parameter int VALUE_BITS = 32,
   parameter int MAX_FIELD_WIDTH = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [VALUE_BITS-1:0]            req_value,
   input  logic [i2af_pkg::BASE_W-1:0]      req_base,
   input  logic                             req_signed_mode,
   input  logic [i2af_pkg::FIELD_W-1:0]     req_field_width,
   input  logic                             req_left_justify,
   input  logic                             req_zero_fill,
   input  logic                             req_uppercase,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [i2af_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_last
);

   i2af_pkg::cmd_type    cmd;
   i2af_pkg::status_type sts;

   // Sequencer for division, text assembly and character output.
   i2af_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Divider, text buffer, pad counters and response register.
   i2af_datapath #(
      .DIGIT_BUFFER_DEPTH (DIGIT_BUFFER_DEPTH),
      .VALUE_BITS         (VALUE_BITS),
      .MAX_FIELD_WIDTH    (MAX_FIELD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_base         (req_base),
      .req_signed_mode  (req_signed_mode),
      .req_field_width  (req_field_width),
      .req_left_justify (req_left_justify),
      .req_zero_fill    (req_zero_fill),
      .req_uppercase    (req_uppercase),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// File: dv/integer_to_ascii_formatter_core_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core_tb;

   localparam int VALUE_BITS = 32;
   localparam int DIGIT_DEPTH = 33;
   localparam int MAX_FIELD_WIDTH = 63;
   localparam int RANDOM_ITEMS = 236;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 250;
   localparam int BASE_W = i2af_pkg::BASE_W;
   localparam int FIELD_W = i2af_pkg::FIELD_W;
   localparam int CHAR_W = i2af_pkg::CHAR_W;

   // One formatting request as the sender offers it.
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [BASE_W-1:0]     base;
      logic                  signed_mode;
      logic [FIELD_W-1:0]    field_width;
      logic                  left_justify;
      logic                  zero_fill;
      logic                  uppercase;
      logic                  wait_idle;
   } fmt_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic [BASE_W-1:0]     req_base = i2af_pkg::DECIMAL_BASE;
   logic                  req_signed_mode = 1'b0;
   logic [FIELD_W-1:0]    req_field_width = '0;
   logic                  req_left_justify = 1'b0;
   logic                  req_zero_fill = 1'b0;
   logic                  req_uppercase = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last;

   fmt_request_type       pending_requests[$];
   logic [CHAR_W:0]       expected_chars[$];
   fmt_request_type       next_request;
   logic                  next_valid;
   bit                    req_taken = 1'b0;
   bit                    rsp_taken = 1'b1;
   bit                    long_hold_done = 1'b0;
   int                    send_gap = 0;
   int                    send_calm = 0;
   int                    recv_gap = 0;
   int                    recv_calm = 0;
   int                    hold_cycles = 0;
   int                    chars_received = 0;
   int                    failures = 0;
   logic [CHAR_W:0]       expected_entry;

   integer_to_ascii_formatter_core #(
      .DIGIT_BUFFER_DEPTH(DIGIT_DEPTH),
      .VALUE_BITS(VALUE_BITS),
      .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_base(req_base),
      .req_signed_mode(req_signed_mode),
      .req_field_width(req_field_width),
      .req_left_justify(req_left_justify),
      .req_zero_fill(req_zero_fill),
      .req_uppercase(req_uppercase),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   // Free-running clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle count for the next transfer; now and then a run of transfers goes without idling.
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   // Builds the characters of one formatted field and appends them, last flag included.
   task automatic format_field(input fmt_request_type r);
      logic [CHAR_W-1:0] digits [DIGIT_DEPTH];
      logic [CHAR_W-1:0] line [$];
      logic [CHAR_W-1:0] letter_a;
      logic [CHAR_W-1:0] pad_char;
      logic [VALUE_BITS-1:0] magnitude;
      int unsigned radix;
      int unsigned width;
      int unsigned text_len;
      int unsigned digit;
      int unsigned count;
      logic negative;
      radix = 32'((r.base < i2af_pkg::MIN_BASE) ? i2af_pkg::MIN_BASE : r.base);
      width = (r.field_width > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : 32'(r.field_width);
      letter_a = r.uppercase ? i2af_pkg::CHAR_UPPER_A : i2af_pkg::CHAR_LOWER_A;
      pad_char = i2af_pkg::CHAR_SPACE;
      text_len = 0;
      negative = 1'b0;
      magnitude = r.value;

      // Digits are collected least significant first.
      if (r.value == '0) begin
         digits[0] = i2af_pkg::CHAR_ZERO;
         text_len = 1;
      end else begin
         if (r.signed_mode && r.base == i2af_pkg::DECIMAL_BASE && r.value[VALUE_BITS-1]) begin
            negative = 1'b1;
            magnitude = -r.value;
         end
         while (magnitude != '0 && text_len < DIGIT_DEPTH) begin
            digit = magnitude % radix;
            digits[text_len] = (digit >= i2af_pkg::CHAR_TEN) ?
                               CHAR_W'(letter_a + digit - i2af_pkg::CHAR_TEN) :
                               CHAR_W'(i2af_pkg::CHAR_ZERO + digit);
            text_len++;
            magnitude = magnitude / radix;
         end
         // A zero-padded negative leads with its sign; otherwise the sign joins the text.
         if (negative) begin
            if (width != 0 && r.zero_fill) begin
               line.push_back(i2af_pkg::CHAR_MINUS);
               width--;
            end else if (text_len < DIGIT_DEPTH) begin
               digits[text_len] = i2af_pkg::CHAR_MINUS;
               text_len++;
            end
         end
      end

      if (width > 0) begin
         width = (text_len >= width) ? 0 : width - text_len;
         if (r.zero_fill) begin
            pad_char = i2af_pkg::CHAR_ZERO;
         end
      end
      if (!r.left_justify) begin
         repeat (width) line.push_back(pad_char);
      end
      for (int i = int'(text_len) - 1; i >= 0; i--) begin
         line.push_back(digits[i]);
      end
      if (r.left_justify) begin
         repeat (width) line.push_back(pad_char);
      end

      // The field is cut at the output limit, and the final kept character carries last.
      count = (line.size() > i2af_pkg::OUT_LIMIT) ? i2af_pkg::OUT_LIMIT : line.size();
      for (int unsigned i = 0; i < count; i++) begin
         expected_chars.push_back({(i == count - 1), line[i]});
      end
   endtask

   task automatic add_request(input logic [VALUE_BITS-1:0] value, input int base,
                              input bit sgn, input int width, input bit right,
                              input bit zero, input bit upper, input bit wait_idle);
      fmt_request_type r;
      r.value = value;
      r.base = BASE_W'(base);
      r.signed_mode = sgn;
      r.field_width = FIELD_W'(width);
      r.left_justify = right;
      r.zero_fill = zero;
      r.uppercase = upper;
      r.wait_idle = wait_idle;
      pending_requests.push_back(r);
   endtask

   // Sender: offers the next pending request once the current one has been taken.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_valid && !req_taken)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].wait_idle && expected_chars.size() != 0)) begin
               next_request = pending_requests.pop_front();
               req_value <= next_request.value;
               req_base <= next_request.base;
               req_signed_mode <= next_request.signed_mode;
               req_field_width <= next_request.field_width;
               req_left_justify <= next_request.left_justify;
               req_zero_fill <= next_request.zero_fill;
               req_uppercase <= next_request.uppercase;
               next_valid = 1'b1;
               send_gap = draw_idle(send_calm);
            end
            req_valid <= next_valid;
         end
         req_taken = 1'b0;
      end
   end

   // Receiver: idles between characters, and holds off once for a long stretch.
   always @(negedge clock) begin
      if (!reset) begin
         if (!long_hold_done && chars_received >= 150) begin
            long_hold_done = 1'b1;
            hold_cycles = LONG_HOLD_CYCLES;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (rsp_taken) begin
               recv_gap = draw_idle(recv_calm);
               rsp_taken = 1'b0;
            end
            if (recv_gap > 0) begin
               recv_gap--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Transfers at the rising edge: requests feed the prediction, characters are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            format_field({req_value, req_base, req_signed_mode, req_field_width,
                          req_left_justify, req_zero_fill, req_uppercase, 1'b0});
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            chars_received++;
            if (expected_chars.size() == 0) begin
               $error("character: expected none, actual %h (last %b)", rsp_character,
                      rsp_last);
               failures++;
            end else begin
               expected_entry = expected_chars.pop_front();
               if (rsp_character !== expected_entry[CHAR_W-1:0]) begin
                  $error("character: expected %h, actual %h", expected_entry[CHAR_W-1:0],
                         rsp_character);
                  failures++;
               end
               if (rsp_last !== expected_entry[CHAR_W]) begin
                  $error("last: expected %b, actual %b", expected_entry[CHAR_W], rsp_last);
                  failures++;
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [VALUE_BITS-1:0] value;
      int base;
      int width;

      // Directed requests: extremes of every field and the corner cases of formatting.
      add_request(32'd0, 10, 0, 0, 0, 0, 0, 0);
      add_request(32'd0, 16, 0, 5, 0, 1, 0, 0);
      add_request(32'd0, 10, 1, 4, 1, 0, 0, 0);
      add_request(32'hFFFF_FFFF, 10, 0, 0, 0, 0, 0, 0);
      add_request(32'hFFFF_FFFF, 10, 1, 0, 0, 0, 0, 0);
      add_request(32'h8000_0000, 10, 1, 0, 0, 0, 0, 0);
      add_request(32'h8000_0000, 10, 1, 15, 0, 1, 0, 0);
      add_request(-32'sd42, 10, 1, 8, 0, 1, 0, 0);
      add_request(-32'sd42, 10, 1, 8, 0, 0, 0, 0);
      add_request(-32'sd42, 10, 1, 8, 1, 1, 0, 0);
      add_request(-32'sd42, 10, 1, 8, 1, 0, 0, 0);
      add_request(32'hDEAD_BEEF, 16, 0, 12, 0, 1, 1, 0);
      add_request(32'hDEAD_BEEF, 16, 1, 0, 0, 0, 0, 0);
      add_request(32'hFFFF_FFFF, 2, 0, 0, 0, 0, 0, 1);
      add_request(32'd5, 0, 0, 0, 0, 0, 0, 0);
      add_request(32'd5, 1, 0, 3, 0, 1, 0, 0);
      add_request(32'hFFFF_FFFF, 31, 0, 0, 0, 0, 1, 0);
      add_request(32'h1234_5678, 17, 1, 10, 1, 0, 0, 0);
      add_request(32'd12345, 8, 0, 0, 0, 0, 0, 0);
      add_request(32'd1234567, 10, 0, 1, 0, 0, 0, 0);
      add_request(32'h7FFF_FFFF, 10, 1, 63, 1, 0, 0, 0);
      add_request(32'hFFFF_FFF9, 10, 1, 63, 0, 1, 0, 0);
      add_request(32'hFFFF_FFFF, 2, 0, 63, 0, 0, 1, 0);
      add_request(32'hABCD_EF01, 16, 0, 63, 1, 1, 1, 0);

      // Random requests, mostly in the bases and widths of real use.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 7))
            0: value = 32'd0;
            1: value = $urandom_range(0, 99);
            2: value = -$urandom_range(1, 1000);
            3: value = {1'b1, 31'($urandom_range(0, 3))};
            4: value = 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: value = $urandom;
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2, 3: base = 10;
            4, 5, 6: base = 16;
            7: base = ($urandom_range(0, 1) != 0) ? 2 : 8;
            default: base = $urandom_range(0, 31);
         endcase
         width = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
         add_request(value, base, $urandom_range(0, 1), width, $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 1), (n == 130));
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Wait for all requests to go out and all characters to come back, then let it settle.
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog for a hung run.
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: integer_to_ascii_formatter_core.f
hw/rtl/i2af_pkg.sv
hw/rtl/i2af_ctrl.sv
hw/rtl/i2af_datapath.sv
hw/rtl/integer_to_ascii_formatter_core.sv
dv/integer_to_ascii_formatter_core_tb.sv
